/* design/btb_pkg.sv */
// ----------------------------------------------------------------------------
// btb_pkg: shared types and constants of the branch target buffer
// Entry count, field widths, command codes and the match result struct.
// ----------------------------------------------------------------------------
package btb_pkg;

  localparam int Entries = 8;
  localparam int IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int AddrW   = 32;
  localparam int CmdW    = 3;
  localparam int SlotW   = 3;

  localparam logic [CmdW-1:0] CmdLookup = 3'd0;
  localparam logic [CmdW-1:0] CmdUpdate = 3'd1;
  localparam logic [CmdW-1:0] CmdToggle = 3'd2;
  localparam logic [CmdW-1:0] CmdClear  = 3'd3;
  localparam logic [CmdW-1:0] CmdRead   = 3'd4;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef struct packed {
    logic match_hit;
    idx_t match_idx;
    logic empty_hit;
    idx_t empty_idx;
  } search_t;

endpackage

/* design/btb_match.sv */
// ----------------------------------------------------------------------------
// btb_match: associative search over all entries
// Compares the address against every valid entry and finds the lowest
// matching entry and the lowest empty entry.
// ----------------------------------------------------------------------------
module btb_match (
  input  logic [btb_pkg::Entries-1:0] valid_i,
  input  btb_pkg::addr_t              branch_i [btb_pkg::Entries],
  input  btb_pkg::addr_t              addr_i,
  output btb_pkg::search_t            search_o
);
  import btb_pkg::*;

  // walk from the top so the lowest index wins
  always_comb begin
    search_o = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_i[i] && (branch_i[i] == addr_i)) begin
        search_o.match_hit = 1'b1;
        search_o.match_idx = IdxW'(i);
      end
      if (!valid_i[i]) begin
        search_o.empty_hit = 1'b1;
        search_o.empty_idx = IdxW'(i);
      end
    end
  end

endmodule

/* design/branch_target_buffer_unit.sv */
// ----------------------------------------------------------------------------
// branch_target_buffer_unit: fully associative branch target buffer
// Lookup, update, toggle, clear and read-by-index commands on a small table.
// ----------------------------------------------------------------------------
// A command is taken whenever start is high; busy never rises, so one command
// can be issued every cycle. The command is registered, then compared against
// all entries in parallel in the following cycle, where the table is written
// and the result registered into done_q and the other result registers; done_o
// is high for one cycle and the result cannot be held off. A command sees every
// table change made by the commands issued before it. The combinational
// parallel compare of the whole table sets the clock rate.
module branch_target_buffer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [btb_pkg::CmdW-1:0]   cmd_i,
  input  btb_pkg::addr_t             branch_addr_i,
  input  btb_pkg::addr_t             target_addr_i,
  input  logic                       flip_i,
  input  logic                       kickout_i,
  input  logic [btb_pkg::SlotW-1:0]  slot_i,
  output logic                       done_o,
  output logic                       ok_o,
  output btb_pkg::addr_t             out_branch_addr_o,
  output btb_pkg::addr_t             out_target_o,
  output logic                       out_taken_o
);
  import btb_pkg::*;

  // request register
  logic              req_valid_q;
  logic [CmdW-1:0]   cmd_q;
  addr_t             branch_addr_q;
  addr_t             target_addr_q;
  logic              flip_q;
  logic              kickout_q;
  logic [SlotW-1:0]  slot_q;

  // table
  logic [Entries-1:0] valid_q, valid_d;
  logic [Entries-1:0] taken_q, taken_d;
  addr_t              branch_q [Entries];
  addr_t              target_q [Entries];

  search_t search;
  idx_t    sel_idx;
  logic    sel_valid;
  addr_t   sel_branch;
  addr_t   sel_target;
  logic    sel_taken;
  logic    wr_entry;

  // result register
  logic  done_q;
  logic  ok_q, ok_d;
  addr_t out_branch_q, out_branch_d;
  addr_t out_target_q, out_target_d;
  logic  out_taken_q, out_taken_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q         <= cmd_i;
      branch_addr_q <= branch_addr_i;
      target_addr_q <= target_addr_i;
      flip_q        <= flip_i;
      kickout_q     <= kickout_i;
      slot_q        <= slot_i;
    end
  end

  btb_match u_match (
    .valid_i  (valid_q),
    .branch_i (branch_q),
    .addr_i   (branch_addr_q),
    .search_o (search)
  );

  always_comb begin
    sel_idx = search.match_idx;
    if (cmd_q == CmdRead) begin
      sel_idx = IdxW'(slot_q);
    end else if (cmd_q == CmdUpdate && !search.match_hit) begin
      sel_idx = search.empty_hit ? search.empty_idx : '0;
    end
  end

  // invalid entries always read as zero addresses
  assign sel_valid  = valid_q[sel_idx];
  assign sel_branch = sel_valid ? branch_q[sel_idx] : '0;
  assign sel_target = sel_valid ? target_q[sel_idx] : '0;
  assign sel_taken  = taken_q[sel_idx];

  always_comb begin
    valid_d      = valid_q;
    taken_d      = taken_q;
    wr_entry     = 1'b0;
    ok_d         = 1'b0;
    out_branch_d = '0;
    out_target_d = '0;
    out_taken_d  = 1'b0;
    if (req_valid_q) begin
      case (cmd_q)
        CmdLookup: begin
          if (search.match_hit) begin
            ok_d         = 1'b1;
            out_branch_d = sel_branch;
            out_target_d = sel_target;
            out_taken_d  = sel_taken;
          end
        end
        CmdUpdate: begin
          if (search.match_hit || search.empty_hit || kickout_q) begin
            wr_entry          = 1'b1;
            valid_d[sel_idx]  = 1'b1;
            taken_d[sel_idx]  = sel_taken ^ flip_q;
            ok_d              = 1'b1;
            out_branch_d      = branch_addr_q;
            out_target_d      = target_addr_q;
            out_taken_d       = sel_taken ^ flip_q;
          end
        end
        CmdToggle: begin
          if (search.match_hit) begin
            taken_d[sel_idx] = sel_taken ^ flip_q;
            ok_d             = 1'b1;
            out_branch_d     = sel_branch;
            out_target_d     = sel_target;
            out_taken_d      = sel_taken ^ flip_q;
          end
        end
        CmdClear: begin
          if (search.match_hit) begin
            valid_d[sel_idx] = 1'b0;
            taken_d[sel_idx] = 1'b1;
            ok_d             = 1'b1;
          end
        end
        CmdRead: begin
          if (32'(slot_q) < 32'(Entries)) begin
            ok_d         = sel_valid;
            out_branch_d = sel_branch;
            out_target_d = sel_target;
            out_taken_d  = sel_taken;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      taken_q <= '1;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      taken_q <= taken_d;
      done_q  <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_entry) begin
      branch_q[sel_idx] <= branch_addr_q;
      target_q[sel_idx] <= target_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q         <= ok_d;
    out_branch_q <= out_branch_d;
    out_target_q <= out_target_d;
    out_taken_q  <= out_taken_d;
  end

  assign done_o            = done_q;
  assign ok_o              = ok_q;
  assign out_branch_addr_o = out_branch_q;
  assign out_target_o      = out_target_q;
  assign out_taken_o       = out_taken_q;

`ifndef NO_ASSERTIONS
  a_done_follows_req : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> done_o
  ) else $error("result strobe missing after registered command");

  a_clear_zero_fields : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && cmd_q == CmdClear) |=>
      (out_branch_addr_o == '0 && out_target_o == '0 && !out_taken_o)
  ) else $error("clear result carries nonzero entry fields");

  a_update_echo_addr : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && cmd_q == CmdUpdate) |=>
      (!ok_o || (out_branch_addr_o == $past(branch_addr_q)
                 && out_target_o == $past(target_addr_q)))
  ) else $error("update result does not match written entry");

  a_update_sets_valid : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && cmd_q == CmdUpdate && wr_entry) |=> valid_q[$past(sel_idx)]
  ) else $error("updated entry not marked valid");
`endif

endmodule

/* tb/btb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_checker: result predictor and comparator for the branch target buffer
// Tracks the table contents from every accepted command, queues the result
// each command must produce and compares every result strobe against the
// oldest queued one, field by field.
// ----------------------------------------------------------------------------
module btb_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [btb_pkg::CmdW-1:0]  cmd_i,
  input  btb_pkg::addr_t            branch_addr_i,
  input  btb_pkg::addr_t            target_addr_i,
  input  logic                      flip_i,
  input  logic                      kickout_i,
  input  logic [btb_pkg::SlotW-1:0] slot_i,
  input  logic                      done_i,
  input  logic                      ok_i,
  input  btb_pkg::addr_t            out_branch_addr_i,
  input  btb_pkg::addr_t            out_target_i,
  input  logic                      out_taken_i,
  output int                        errors_o,
  output int                        pending_o
);
  import btb_pkg::*;

  typedef struct packed {
    logic  ok;
    addr_t branch;
    addr_t target;
    logic  taken;
  } btb_result_t;

  logic  valid_q  [Entries];
  addr_t branch_q [Entries];
  addr_t target_q [Entries];
  logic  taken_q  [Entries];

  btb_result_t expected_q[$];

  function automatic btb_result_t entry_view(int i);
    btb_result_t r;
    r.ok     = 1'b1;
    r.branch = branch_q[i];
    r.target = target_q[i];
    r.taken  = taken_q[i];
    return r;
  endfunction

  // lowest valid entry holding the address, -1 when none
  function automatic int find_entry(addr_t addr);
    for (int i = 0; i < Entries; i++) begin
      if (valid_q[i] && branch_q[i] == addr) return i;
    end
    return -1;
  endfunction

  task automatic predict_command(input logic [CmdW-1:0] cmd, input addr_t addr,
                                 input addr_t tgt, input logic flip, input logic kick,
                                 input logic [SlotW-1:0] slot,
                                 output btb_result_t res);
    int sel;
    res = '0;
    sel = find_entry(addr);
    case (cmd)
      CmdLookup: begin
        if (sel >= 0) res = entry_view(sel);
      end
      CmdUpdate: begin
        if (sel < 0) begin
          for (int i = Entries - 1; i >= 0; i--) begin
            if (!valid_q[i]) sel = i;
          end
          if (sel < 0 && kick) sel = 0;
          if (sel >= 0) begin
            valid_q[sel]  = 1'b1;
            branch_q[sel] = addr;
          end
        end
        if (sel >= 0) begin
          target_q[sel] = tgt;
          taken_q[sel]  = taken_q[sel] ^ flip;
          res = entry_view(sel);
        end
      end
      CmdToggle: begin
        if (sel >= 0) begin
          taken_q[sel] = taken_q[sel] ^ flip;
          res = entry_view(sel);
        end
      end
      CmdClear: begin
        if (sel >= 0) begin
          valid_q[sel]  = 1'b0;
          branch_q[sel] = '0;
          target_q[sel] = '0;
          taken_q[sel]  = 1'b1;
          res.ok = 1'b1;
        end
      end
      CmdRead: begin
        if (slot < Entries) begin
          res = entry_view(slot);
          res.ok = valid_q[slot];
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [AddrW-1:0] exp_val,
                             input logic [AddrW-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    btb_result_t exp_res;
    btb_result_t new_res;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        valid_q[i]  = 1'b0;
        branch_q[i] = '0;
        target_q[i] = '0;
        taken_q[i]  = 1'b1;
      end
      expected_q.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, actual ok %b branch %h target %h taken %b",
                   $time, ok_i, out_branch_addr_i, out_target_i, out_taken_i);
          errors_o++;
        end else begin
          exp_res = expected_q.pop_front();
          check_field("ok", exp_res.ok, ok_i);
          check_field("out_branch_addr", exp_res.branch, out_branch_addr_i);
          check_field("out_target", exp_res.target, out_target_i);
          check_field("out_taken", exp_res.taken, out_taken_i);
        end
      end
      // command transfer
      if (start_i && !busy_i) begin
        predict_command(cmd_i, branch_addr_i, target_addr_i, flip_i, kickout_i, slot_i,
                        new_res);
        expected_q.push_back(new_res);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the branch target buffer unit
// Drives directed and random command streams with varying idle gaps; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import btb_pkg::*;

  localparam int StallLimit = 1000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CmdW-1:0]   cmd_i;
  addr_t             branch_addr_i;
  addr_t             target_addr_i;
  logic              flip_i;
  logic              kickout_i;
  logic [SlotW-1:0]  slot_i;
  logic              done_o;
  logic              ok_o;
  addr_t             out_branch_addr_o;
  addr_t             out_target_o;
  logic              out_taken_o;
  int                errors;
  int                pending;
  int                stall_cycles;

  addr_t addr_pool [16];

  branch_target_buffer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .branch_addr_i    (branch_addr_i),
    .target_addr_i    (target_addr_i),
    .flip_i           (flip_i),
    .kickout_i        (kickout_i),
    .slot_i           (slot_i),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .out_branch_addr_o(out_branch_addr_o),
    .out_target_o     (out_target_o),
    .out_taken_o      (out_taken_o)
  );

  btb_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .cmd_i            (cmd_i),
    .branch_addr_i    (branch_addr_i),
    .target_addr_i    (target_addr_i),
    .flip_i           (flip_i),
    .kickout_i        (kickout_i),
    .slot_i           (slot_i),
    .done_i           (done_o),
    .ok_i             (ok_o),
    .out_branch_addr_i(out_branch_addr_o),
    .out_target_i     (out_target_o),
    .out_taken_i      (out_taken_o),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog on cycles without any transfer or result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic issue(input logic [CmdW-1:0] cmd, input addr_t addr, input addr_t tgt,
                       input logic flip, input logic kick, input logic [SlotW-1:0] slot);
    logic taken;
    cmd_i         <= cmd;
    branch_addr_i <= addr;
    target_addr_i <= tgt;
    flip_i        <= flip;
    kickout_i     <= kick;
    slot_i        <= slot;
    start         <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      // busy only moves on rising edges, so this is what the next edge sees
      taken = !busy;
      @(negedge clk_i);
    end
  endtask

  task automatic run_random(input int count, input int idle_pct);
    int          pick;
    logic [CmdW-1:0] cmd;
    addr_t       addr;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 16; i++) addr_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      // each cycle is idle with the given percentage
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 25)      cmd = CmdLookup;
      else if (pick < 55) cmd = CmdUpdate;
      else if (pick < 67) cmd = CmdToggle;
      else if (pick < 80) cmd = CmdClear;
      else if (pick < 95) cmd = CmdRead;
      else                cmd = CmdW'($urandom_range(5, 7));
      addr = ($urandom_range(9) == 0) ? addr_t'($urandom) : addr_pool[$urandom_range(15)];
      issue(cmd, addr, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
            SlotW'($urandom_range(7)));
    end
  endtask

  initial begin
    int waited;
    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd_i         = CmdLookup;
    branch_addr_i = '0;
    target_addr_i = '0;
    flip_i        = 1'b0;
    kickout_i     = 1'b0;
    slot_i        = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, extremes, fill, full table, eviction, clear
    issue(CmdLookup, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 3'd0);
    issue(CmdRead,   32'h0000_0000, 32'h0, 1'b0, 1'b0, 3'd0);
    issue(CmdRead,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7);
    issue(CmdUpdate, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0);
    issue(CmdUpdate, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 3'd0);
    issue(CmdLookup, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, 3'd0);
    issue(CmdToggle, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 3'd0);
    issue(CmdToggle, 32'h1234_5678, 32'h0, 1'b1, 1'b0, 3'd0);
    issue(CmdUpdate, 32'h0000_0000, 32'hA5A5_5A5A, 1'b1, 1'b0, 3'd0);
    for (int i = 2; i < Entries; i++) begin
      issue(CmdUpdate, 32'h1000_0000 + i, 32'h2000_0000 + i, i[0], 1'b0, 3'd0);
    end
    issue(CmdUpdate, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1, 1'b0, 3'd0);
    issue(CmdUpdate, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1, 1'b1, 3'd0);
    issue(CmdClear,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd1);
    issue(CmdClear,  32'h5555_AAAA, 32'h0, 1'b0, 1'b0, 3'd0);
    issue(CmdUpdate, 32'h8000_0001, 32'h7FFF_FFFE, 1'b0, 1'b0, 3'd0);
    issue(CmdW'(5),  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7);
    issue(CmdW'(7),  32'hDEAD_BEEF, 32'h0, 1'b1, 1'b1, 3'd1);
    issue(CmdRead,   32'h0, 32'h0, 1'b0, 1'b0, 3'd1);
    issue(CmdRead,   32'h0, 32'h0, 1'b0, 1'b0, 3'd0);
    issue(CmdLookup, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 3'd0);

    // random phases: back to back, sparse, back to back, moderate
    run_random(320, 0);
    run_random(310, 46);
    run_random(310, 0);
    run_random(310, 38);
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/btb_pkg.sv
design/btb_match.sv
design/branch_target_buffer_unit.sv
tb/btb_checker.sv
tb/tb_top.sv
